[rtl/core/periodic_task_timer_table_top_macros.svh]
// assertion macros for the periodic task timer table
`ifndef PERIODIC_TASK_TIMER_TABLE_TOP_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PTT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptt check failed");

// next-cycle implication, checked outside reset
`define PTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptt check failed");

`endif

[rtl/core/ptt_pkg.sv]
// shared types and constants for the periodic task timer table
package ptt_pkg;

  localparam int SLOTS   = 8;
  localparam int MAX_OUT = 8;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  localparam int ACT_W    = 3;
  localparam int ID_W     = 8;
  localparam int SECS_W   = 16;
  localparam int TIME_W   = 32;
  localparam int GRAN_W   = 12;
  localparam int SFAC_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam logic [ACT_W-1:0] ACT_ADD     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ENABLE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DISABLE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_TICK    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_GRANULARITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOWDOWN    = 2'd1;

  localparam logic [GRAN_W-1:0] GRAN_RESET = 12'd5;
  localparam logic [SFAC_W-1:0] SFAC_RESET = 8'd20;
  localparam logic [TIME_W-1:0] MS_PER_S   = 32'd1000;

  typedef struct packed {
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] period_ms;
    logic [TIME_W-1:0] due_ms;
    logic              slow;
  } slot_t;

endpackage

[rtl/core/ptt_intf.sv]
// valid/ready channel interfaces of the timer table
interface ptt_in_if;
  logic                           valid;
  logic                           ready;
  logic [ptt_pkg::ACT_W-1:0]      action;
  logic [ptt_pkg::ID_W-1:0]       task_id;
  logic [ptt_pkg::SECS_W-1:0]     interval_s;
  logic                           slowdown;
  logic                           connected;
  logic [ptt_pkg::TIME_W-1:0]     now_ms;

  modport source (output valid, action, task_id, interval_s, slowdown, connected, now_ms,
                  input ready);
  modport sink (input valid, action, task_id, interval_s, slowdown, connected, now_ms,
                output ready);
endinterface

interface ptt_out_if;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic                     fired;
  logic [ptt_pkg::ID_W-1:0] fired_id;
  logic                     last;

  modport source (output valid, ok, fired, fired_id, last, input ready);
  modport sink (input valid, ok, fired, fired_id, last, output ready);
endinterface

interface ptt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ptt_pkg::CFG_IDX_W-1:0] index;
  logic [ptt_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/ptt_ram.sv]
// generic single-write, single-read ram with registered read data
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ptt_period.sv]
// interval to period: remainder by granularity, one bit a cycle, then scale to ms
module ptt_period (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ptt_pkg::SECS_W-1:0]   secs,
  input  logic [ptt_pkg::GRAN_W-1:0]   gran,
  output logic                         done,
  output logic [ptt_pkg::TIME_W-1:0]   period_ms
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIV  = 2'd1;
  localparam logic [1:0] PH_SEL  = 2'd2;
  localparam logic [1:0] PH_MUL  = 2'd3;
  localparam int STEP_W = $clog2(ptt_pkg::SECS_W);

  logic [1:0]                    phase_r;
  logic [STEP_W-1:0]             step_r;
  logic [ptt_pkg::SECS_W-1:0]    secs_r;
  logic [ptt_pkg::SECS_W-1:0]    num_r;
  logic [ptt_pkg::GRAN_W-1:0]    g_r;
  logic [ptt_pkg::GRAN_W-1:0]    rem_r;
  logic [ptt_pkg::SECS_W-1:0]    s_r;
  logic [ptt_pkg::GRAN_W:0]      trial;
  logic [ptt_pkg::SECS_W-1:0]    g_ext;

  assign trial = {rem_r, num_r[ptt_pkg::SECS_W-1]};
  assign g_ext = ptt_pkg::SECS_W'(g_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (start) begin
            phase_r <= PH_DIV;
            step_r  <= '0;
            secs_r  <= secs;
            num_r   <= secs;
            rem_r   <= '0;
            // zero granularity counts as one second
            g_r     <= (gran == '0) ? ptt_pkg::GRAN_W'(1) : gran;
          end
        end
        PH_DIV: begin
          if (trial >= {1'b0, g_r}) begin
            rem_r <= ptt_pkg::GRAN_W'(trial - {1'b0, g_r});
          end else begin
            rem_r <= ptt_pkg::GRAN_W'(trial);
          end
          num_r  <= num_r << 1;
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(ptt_pkg::SECS_W - 1)) begin
            phase_r <= PH_SEL;
          end
        end
        PH_SEL: begin
          s_r     <= (secs_r < g_ext) ? g_ext : secs_r - ptt_pkg::SECS_W'(rem_r);
          phase_r <= PH_MUL;
        end
        PH_MUL: begin
          phase_r <= PH_IDLE;
        end
        default: begin
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  assign done      = (phase_r == PH_MUL);
  assign period_ms = ptt_pkg::TIME_W'(s_r) * ptt_pkg::MS_PER_S;

endmodule

[rtl/core/periodic_task_timer_table_top.sv]
// periodic task timer table: slot memory walk, add path and result register
//
//  channel  dir  beat carries
//  in_chan  in   action, task_id, interval_s, slowdown, connected, now_ms
//  out_chan out  ok, fired, fired_id, last
//  cfg_chan in   index, data (always ready)
//
// remove, enable all and tick walk the slot memory one slot a cycle unless stalled;
// add runs the bit-serial remainder, but skips it on a full table; disable all and
// unknown actions go straight to the final beat. rst_n (synchronous) frees and
// disarms all slots at once. a tick stalls its walk while a due slot meets a full
// result register, and every item holds its final beat until that register frees;
// in_chan is ready only between items.
`include "periodic_task_timer_table_top_macros.svh"

module periodic_task_timer_table_top (
  input  logic         clk,
  input  logic         rst_n,
  ptt_in_if.sink       in_chan,
  ptt_out_if.source    out_chan,
  ptt_cfg_if.sink      cfg_chan
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int AW = ptt_pkg::SLOT_AW;
  localparam int N  = ptt_pkg::SLOTS;

  logic [1:0]                      state_r, state_nxt;
  logic [AW-1:0]                   idx_r, idx_nxt;
  logic [ptt_pkg::ACT_W-1:0]       act_r;
  logic [ptt_pkg::ID_W-1:0]        id_r;
  logic                            slow_in_r;
  logic                            conn_r;
  logic [ptt_pkg::TIME_W-1:0]      now_r;
  logic [AW-1:0]                   add_idx_r;
  logic                            ok_r, ok_nxt;
  logic                            pend_v_r, pend_v_nxt;
  logic [ptt_pkg::ID_W-1:0]        pend_id_r, pend_id_nxt;
  logic [ptt_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [N-1:0]                    used_r, used_nxt;
  logic [N-1:0]                    en_r, en_nxt;
  logic [ptt_pkg::GRAN_W-1:0]      gran_r;
  logic [ptt_pkg::SFAC_W-1:0]      sfac_r;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_ok_r, out_ok_nxt;
  logic                            out_fired_r, out_fired_nxt;
  logic [ptt_pkg::ID_W-1:0]        out_id_r, out_id_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            in_fire;
  logic                            out_free;
  logic [AW-1:0]                   free_idx;
  logic                            free_any;

  logic                            ram_we, ram_re;
  logic [AW-1:0]                   ram_waddr, ram_raddr;
  ptt_pkg::slot_t                  ram_wdata, rd;
  logic [$bits(ptt_pkg::slot_t)-1:0] ram_rdata;

  logic                            per_start, per_done;
  logic [ptt_pkg::TIME_W-1:0]      per_ms;

  logic                            last_slot, hit_rm, arm, due_now, stall;
  logic [ptt_pkg::TIME_W+ptt_pkg::SFAC_W-1:0] slow_prod;
  logic [ptt_pkg::TIME_W-1:0]      step_ms;

  ptt_ram #(
    .WIDTH ($bits(ptt_pkg::slot_t)),
    .DEPTH (ptt_pkg::SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptt_period u_period (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (per_start),
    .secs      (in_chan.interval_s),
    .gran      (gran_r),
    .done      (per_done),
    .period_ms (per_ms)
  );

  assign rd       = ptt_pkg::slot_t'(ram_rdata);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // first free slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = AW'(i);
        free_any = 1'b1;
      end
    end
  end

  // per-slot decisions on the slot whose data sits at the ram output
  assign last_slot = (idx_r == AW'(N - 1));
  assign hit_rm    = (act_r == ptt_pkg::ACT_REMOVE) && used_r[idx_r] &&
                     (rd.task_id == id_r) && !ok_r;
  assign arm       = (act_r == ptt_pkg::ACT_ENABLE) && used_r[idx_r];
  assign due_now   = (act_r == ptt_pkg::ACT_TICK) && used_r[idx_r] && en_r[idx_r] &&
                     (now_r >= rd.due_ms) && (cnt_r < ptt_pkg::CNT_W'(ptt_pkg::MAX_OUT));
  assign stall     = due_now && pend_v_r && !out_free;
  assign slow_prod = rd.period_ms * sfac_r;
  assign step_ms   = (!arm && rd.slow && !conn_r) ? slow_prod[ptt_pkg::TIME_W-1:0]
                                                  : rd.period_ms;

  assign per_start = in_fire && (in_chan.action == ptt_pkg::ACT_ADD) && free_any;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ok_nxt        = ok_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    cnt_nxt       = cnt_r;
    used_nxt      = used_r;
    en_nxt        = en_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_ok_nxt    = out_ok_r;
    out_fired_nxt = out_fired_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = '{task_id: rd.task_id, period_ms: rd.period_ms,
                      due_ms: now_r + step_ms, slow: rd.slow};
    ram_re        = 1'b0;
    ram_raddr     = idx_r + AW'(1);

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ok_nxt     = 1'b0;
          pend_v_nxt = 1'b0;
          cnt_nxt    = '0;
          idx_nxt    = '0;
          case (in_chan.action)
            ptt_pkg::ACT_ADD: begin
              state_nxt = free_any ? ST_ADD : ST_DONE;
            end
            ptt_pkg::ACT_REMOVE, ptt_pkg::ACT_ENABLE, ptt_pkg::ACT_TICK: begin
              state_nxt = ST_WALK;
              ram_re    = 1'b1;
              ram_raddr = '0;
            end
            ptt_pkg::ACT_DISABLE: begin
              en_nxt    = '0;
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_ADD: begin
        if (per_done) begin
          ram_we    = 1'b1;
          ram_waddr = add_idx_r;
          ram_wdata = '{task_id: id_r, period_ms: per_ms, due_ms: '0, slow: slow_in_r};
          used_nxt[add_idx_r] = 1'b1;
          en_nxt[add_idx_r]   = 1'b0;
          ok_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_WALK: begin
        if (!stall) begin
          if (hit_rm) begin
            used_nxt[idx_r] = 1'b0;
            en_nxt[idx_r]   = 1'b0;
            ok_nxt          = 1'b1;
          end
          if (arm) begin
            en_nxt[idx_r] = 1'b1;
            ram_we        = 1'b1;
          end
          if (due_now) begin
            ram_we = 1'b1;
            // a held report goes out once the next due slot proves it is not last
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_ok_nxt    = 1'b0;
              out_fired_nxt = 1'b1;
              out_id_nxt    = pend_id_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = rd.task_id;
            cnt_nxt     = cnt_r + ptt_pkg::CNT_W'(1);
          end
          if (last_slot) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt = idx_r + AW'(1);
            ram_re  = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = pend_v_r ? 1'b0 : ok_r;
          out_fired_nxt = pend_v_r;
          out_id_nxt    = pend_v_r ? pend_id_r : '0;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ok_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      used_r      <= '0;
      en_r        <= '0;
      out_valid_r <= 1'b0;
      gran_r      <= ptt_pkg::GRAN_RESET;
      sfac_r      <= ptt_pkg::SFAC_RESET;
    end else begin
      state_r     <= state_nxt;
      ok_r        <= ok_nxt;
      pend_v_r    <= pend_v_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          ptt_pkg::CFG_GRANULARITY: gran_r <= cfg_chan.data;
          ptt_pkg::CFG_SLOWDOWN:    sfac_r <= cfg_chan.data[ptt_pkg::SFAC_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pend_id_r   <= pend_id_nxt;
    out_ok_r    <= out_ok_nxt;
    out_fired_r <= out_fired_nxt;
    out_id_r    <= out_id_nxt;
    out_last_r  <= out_last_nxt;
    if (in_fire) begin
      act_r     <= in_chan.action;
      id_r      <= in_chan.task_id;
      slow_in_r <= in_chan.slowdown;
      conn_r    <= in_chan.connected;
      now_r     <= in_chan.now_ms;
      add_idx_r <= free_idx;
    end
  end

  assign in_chan.ready     = (state_r == ST_IDLE);
  assign cfg_chan.ready    = 1'b1;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.ok       = out_ok_r;
  assign out_chan.fired    = out_fired_r;
  assign out_chan.fired_id = out_id_r;
  assign out_chan.last     = out_last_r;

  `PTT_ASSERT_NOW(a_en_within_used, 1'b1, (en_r & ~used_r) == '0)
  `PTT_ASSERT_NOW(a_mid_beat_is_fire, out_chan.valid && !out_chan.last, out_chan.fired)
  `PTT_ASSERT_NOW(a_period_only_in_add, per_done, state_r == ST_ADD)
  `PTT_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_chan.ready)

endmodule

[sim/tb_periodic_task_timer_table_top.sv]
// self-checking testbench for the periodic task timer table: directed and random commands
module tb_periodic_task_timer_table_top;

  typedef struct packed {
    logic [ptt_pkg::ACT_W-1:0]  action;
    logic [ptt_pkg::ID_W-1:0]   task_id;
    logic [ptt_pkg::SECS_W-1:0] interval_s;
    logic                       slowdown;
    logic                       connected;
    logic [ptt_pkg::TIME_W-1:0] now_ms;
  } timer_cmd_t;

  typedef struct packed {
    logic                     ok;
    logic                     fired;
    logic [ptt_pkg::ID_W-1:0] fired_id;
    logic                     last;
  } report_t;

  // slot table mirror plus the queue of reports still owed by the block
  class timer_table_board;
    bit [ptt_pkg::GRAN_W-1:0]   gran;
    bit [ptt_pkg::SFAC_W-1:0]   sfac;
    bit                         used [ptt_pkg::SLOTS];
    bit [ptt_pkg::ID_W-1:0]     ids [ptt_pkg::SLOTS];
    bit [ptt_pkg::TIME_W-1:0]   period [ptt_pkg::SLOTS];
    bit [ptt_pkg::TIME_W-1:0]   due [ptt_pkg::SLOTS];
    bit                         enabled [ptt_pkg::SLOTS];
    bit                         slow [ptt_pkg::SLOTS];
    report_t                    pending_reports[$];
    int                         mismatches, n_cmds, n_add, n_full, n_remove, n_tick;
    int                         n_reports, n_fires;

    function new();
      gran = ptt_pkg::GRAN_RESET;
      sfac = ptt_pkg::SFAC_RESET;
      for (int i = 0; i < ptt_pkg::SLOTS; i++) begin
        used[i] = 1'b0;
        enabled[i] = 1'b0;
      end
    endfunction

    function void set_reg(logic [ptt_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
      if (idx == ptt_pkg::CFG_GRANULARITY) gran = val[ptt_pkg::GRAN_W-1:0];
      else if (idx == ptt_pkg::CFG_SLOWDOWN) sfac = val[ptt_pkg::SFAC_W-1:0];
    endfunction

    function bit [ptt_pkg::TIME_W-1:0] period_ms_for(bit [ptt_pkg::SECS_W-1:0] secs);
      bit [ptt_pkg::TIME_W-1:0] g;
      bit [ptt_pkg::TIME_W-1:0] s;
      g = (gran == 0) ? 1 : ptt_pkg::TIME_W'(gran);
      if (ptt_pkg::TIME_W'(secs) < g) s = g;
      else s = ptt_pkg::TIME_W'(secs) - (ptt_pkg::TIME_W'(secs) % g);
      return s * ptt_pkg::MS_PER_S;
    endfunction

    function void note_item(timer_cmd_t c);
      bit [ptt_pkg::SLOTS-1:0]  hit;
      int                       cnt, k;
      bit                       found;
      bit [ptt_pkg::TIME_W-1:0] p;
      report_t                  r;
      found = 1'b0;
      hit = '0;
      n_cmds++;
      case (c.action)
        ptt_pkg::ACT_ADD: begin
          n_add++;
          for (int i = 0; i < ptt_pkg::SLOTS; i++) begin
            if (!found && !used[i]) begin
              used[i] = 1'b1;
              ids[i] = c.task_id;
              period[i] = period_ms_for(c.interval_s);
              due[i] = '0;
              enabled[i] = 1'b0;
              slow[i] = c.slowdown;
              found = 1'b1;
            end
          end
          if (!found) n_full++;
        end
        ptt_pkg::ACT_REMOVE: begin
          n_remove++;
          for (int i = 0; i < ptt_pkg::SLOTS; i++) begin
            if (!found && used[i] && ids[i] == c.task_id) begin
              used[i] = 1'b0;
              enabled[i] = 1'b0;
              found = 1'b1;
            end
          end
        end
        ptt_pkg::ACT_ENABLE: begin
          for (int i = 0; i < ptt_pkg::SLOTS; i++) begin
            if (used[i]) begin
              enabled[i] = 1'b1;
              due[i] = c.now_ms + period[i];
            end
          end
        end
        ptt_pkg::ACT_DISABLE: begin
          for (int i = 0; i < ptt_pkg::SLOTS; i++)
            if (used[i]) enabled[i] = 1'b0;
        end
        ptt_pkg::ACT_TICK: begin
          n_tick++;
          // due slots past the report limit stay due for a later tick
          for (int i = 0; i < ptt_pkg::SLOTS; i++)
            hit[i] = used[i] && enabled[i] && (c.now_ms >= due[i]) &&
                     ($countones(hit) < ptt_pkg::MAX_OUT);
        end
        default: ;
      endcase
      cnt = $countones(hit);
      if (cnt == 0) begin
        r.ok = found;
        r.fired = 1'b0;
        r.fired_id = '0;
        r.last = 1'b1;
        pending_reports.push_back(r);
      end else begin
        k = 0;
        for (int i = 0; i < ptt_pkg::SLOTS; i++) begin
          if (hit[i]) begin
            p = period[i];
            if (slow[i] && !c.connected) p = p * ptt_pkg::TIME_W'(sfac);
            due[i] = c.now_ms + p;
            r.ok = 1'b0;
            r.fired = 1'b1;
            r.fired_id = ids[i];
            r.last = (k == cnt - 1);
            pending_reports.push_back(r);
            k++;
          end
        end
      end
    endfunction

    function void check_result(logic ok, logic fired, logic [ptt_pkg::ID_W-1:0] fired_id,
                               logic last);
      report_t want;
      n_reports++;
      if (fired === 1'b1) n_fires++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: ok=%0b fired=%0b id=%0d last=%0b",
                   ok, fired, fired_id, last);
        return;
      end
      want = pending_reports.pop_front();
      if (ok !== want.ok || fired !== want.fired || fired_id !== want.fired_id ||
          last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report mismatch: want ok=%0b fired=%0b id=%0d last=%0b, ",
                   want.ok, want.fired, want.fired_id, want.last,
                   "got ok=%0b fired=%0b id=%0d last=%0b", ok, fired, fired_id, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ptt_in_if  in_chan ();
  ptt_out_if out_chan ();
  ptt_cfg_if cfg_chan ();

  periodic_task_timer_table_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  timer_table_board sb = new();

  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 49;
  int unsigned clock_ms = 0;
  int unsigned gran_set [6];
  int unsigned sfac_set [6];
  int          n_settings = 1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result(out_chan.ok, out_chan.fired, out_chan.fired_id, out_chan.last);
  end

  initial begin
    #12_000_000;
    $display("periodic_task_timer_table_top verification failed");
    $finish;
  end

  function automatic timer_cmd_t mk(logic [ptt_pkg::ACT_W-1:0] act,
                                    logic [ptt_pkg::ID_W-1:0] id,
                                    logic [ptt_pkg::SECS_W-1:0] secs, logic slw, logic conn,
                                    logic [ptt_pkg::TIME_W-1:0] now);
    timer_cmd_t c;
    c.action = act;
    c.task_id = id;
    c.interval_s = secs;
    c.slowdown = slw;
    c.connected = conn;
    c.now_ms = now;
    return c;
  endfunction

  // mostly a small id pool so removes hit, interval near a few granules, time moving forward
  function automatic timer_cmd_t random_cmd();
    timer_cmd_t  c;
    int unsigned pick, g, lim;
    c = mk(ptt_pkg::ACT_TICK, ptt_pkg::ID_W'($urandom), ptt_pkg::SECS_W'($urandom),
           1'($urandom), 1'($urandom), $urandom);
    g = (sb.gran == 0) ? 1 : 32'(sb.gran);
    lim = (g * 4 > 65535) ? 65535 : g * 4;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      c.action = ptt_pkg::ACT_ADD;
      if ($urandom_range(0, 3) != 0) c.task_id = ptt_pkg::ID_W'($urandom_range(0, 15));
      if ($urandom_range(0, 7) != 0) c.interval_s = ptt_pkg::SECS_W'($urandom_range(0, lim));
    end else if (pick < 36) begin
      c.action = ptt_pkg::ACT_REMOVE;
      if ($urandom_range(0, 3) != 0) c.task_id = ptt_pkg::ID_W'($urandom_range(0, 15));
    end else if (pick < 44) begin
      c.action = ptt_pkg::ACT_ENABLE;
      c.now_ms = clock_ms;
    end else if (pick < 48) begin
      c.action = ptt_pkg::ACT_DISABLE;
    end else if (pick < 94) begin
      c.action = ptt_pkg::ACT_TICK;
      if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, g * 2500);
      c.now_ms = clock_ms;
      c.connected = ($urandom_range(0, 3) != 0);
    end else begin
      c.action = ptt_pkg::ACT_W'(ptt_pkg::ACT_TICK + $urandom_range(1, 3));
    end
    return c;
  endfunction

  // valid stays up between back-to-back beats; it only drops in an idle cycle
  task automatic send_cmd(input timer_cmd_t c);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.action     <= c.action;
    in_chan.task_id    <= c.task_id;
    in_chan.interval_s <= c.interval_s;
    in_chan.slowdown   <= c.slowdown;
    in_chan.connected  <= c.connected;
    in_chan.now_ms     <= c.now_ms;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_item(c);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ptt_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val[ptt_pkg::CFG_DAT_W-1:0];
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.action = ptt_pkg::ACT_ADD;
    in_chan.task_id = '0;
    in_chan.interval_s = '0;
    in_chan.slowdown = 1'b0;
    in_chan.connected = 1'b0;
    in_chan.now_ms = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = ptt_pkg::CFG_GRANULARITY;
    cfg_chan.data = '0;
    gran_set = '{1, 3600, 0, 0, 5, 0};
    sfac_set = '{255, 1, 0, 0, 20, 0};
    gran_set[3] = $urandom_range(1, 3600);
    sfac_set[3] = $urandom_range(1, 255);
    gran_set[5] = $urandom_range(1, 60);
    sfac_set[5] = $urandom_range(1, 255);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table, fill to full, fire with and without slowdown, wrap of due time
    send_cmd(mk(ptt_pkg::ACT_TICK, 8'h00, 16'h0000, 1'b0, 1'b1, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_REMOVE, 8'h07, 16'h0000, 1'b0, 1'b0, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_ENABLE, 8'h00, 16'h0000, 1'b0, 1'b0, 32'd100));
    send_cmd(mk(ptt_pkg::ACT_DISABLE, 8'h00, 16'h0000, 1'b0, 1'b0, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_ADD, 8'h00, 16'd0, 1'b0, 1'b0, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_ADD, 8'hFF, 16'hFFFF, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_cmd(mk(ptt_pkg::ACT_ADD, 8'h5A, 16'd7, 1'b1, 1'b1, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_ADD, 8'h01, 16'd5, 1'b0, 1'b0, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_ADD, 8'h02, 16'd6, 1'b1, 1'b0, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_ADD, 8'h03, 16'd12, 1'b0, 1'b0, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_ADD, 8'h04, 16'd3, 1'b1, 1'b0, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_ADD, 8'h05, 16'd10, 1'b0, 1'b0, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_ADD, 8'h09, 16'd20, 1'b0, 1'b0, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_ENABLE, 8'h00, 16'h0000, 1'b0, 1'b0, 32'd1000));
    send_cmd(mk(ptt_pkg::ACT_TICK, 8'h00, 16'h0000, 1'b0, 1'b1, 32'd5999));
    send_cmd(mk(ptt_pkg::ACT_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 32'd6000));
    send_cmd(mk(ptt_pkg::ACT_REMOVE, 8'h00, 16'h0000, 1'b0, 1'b0, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_REMOVE, 8'h77, 16'h0000, 1'b0, 1'b0, 32'd0));
    for (int u = 1; u <= 3; u++)
      send_cmd(mk(ptt_pkg::ACT_W'(ptt_pkg::ACT_TICK + u), ptt_pkg::ID_W'($urandom),
                  ptt_pkg::SECS_W'($urandom), 1'($urandom), 1'($urandom), $urandom));
    send_cmd(mk(ptt_pkg::ACT_ADD, 8'hAA, 16'd1, 1'b0, 1'b0, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_ENABLE, 8'h00, 16'h0000, 1'b0, 1'b0, 32'hFFFF_F000));
    send_cmd(mk(ptt_pkg::ACT_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_cmd(mk(ptt_pkg::ACT_DISABLE, 8'h00, 16'h0000, 1'b0, 1'b0, 32'd0));
    send_cmd(mk(ptt_pkg::ACT_TICK, 8'h00, 16'h0000, 1'b0, 1'b1, 32'hFFFF_FFFF));
    wait_quiet();

    for (int b = 0; b < 6; b++) begin
      send_idle_pct = (b < 2) ? 11 : (b < 4) ? 49 : 0;
      recv_idle_pct = (b < 2) ? 49 : (b < 4) ? 11 : 0;
      write_reg(ptt_pkg::CFG_GRANULARITY, gran_set[b]);
      write_reg(ptt_pkg::CFG_SLOWDOWN, sfac_set[b]);
      n_settings++;
      for (int k = 0; k < 85; k++) begin
        // let the block drain completely midway through each setting
        if (k == 42) wait_quiet();
        send_cmd(random_cmd());
      end
      wait_quiet();
    end

    $display("sent %0d commands: %0d adds (%0d on a full table), %0d removes, %0d ticks",
             sb.n_cmds, sb.n_add, sb.n_full, sb.n_remove, sb.n_tick);
    $display("checked %0d reports, %0d of them task firings, under %0d register settings",
             sb.n_reports, sb.n_fires, n_settings);
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("periodic_task_timer_table_top verification clean");
    end else begin
      $display("periodic_task_timer_table_top verification failed");
    end
    $finish;
  end

endmodule
